// File: sv/pss_pkg.sv
// shared types and constants for the positional sequence store
// no dependencies; used by pss_decode, pss_cell and the top level
`default_nettype none

package pss_pkg;

  // fixed field widths
  localparam int DATA_W = 32;
  localparam int POS_W  = 7;
  localparam int CNT_W  = 7;

  // action codes
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_INSERT_AT  = 3'd4,
    ACT_ERASE_AT   = 3'd5
  } act_t;

  // shift command broadcast to every cell of the chain
  typedef struct packed {
    logic place;  // open a gap at the target and write the new word there
    logic take;   // close the gap left by the word at the target
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: sv/pss_decode.sv
// action decoder: target index, legality checks and cell shift command
// depends on pss_pkg
`default_nettype none

module pss_decode #(
  parameter int CAPACITY = 64,
  parameter int LW       = 7,
  parameter int PW       = 7
) (
  input  wire logic                     go,
  input  wire logic [2:0]               action,
  input  wire logic [pss_pkg::POS_W-1:0] position,
  input  wire logic [LW-1:0]            length,
  output pss_pkg::cell_ctrl_t           ctrl,
  output logic [PW-1:0]                 tpos,
  output logic                          ok
);

  pss_pkg::act_t act;
  logic [PW-1:0] len_ext;
  logic [PW-1:0] pos_ext;
  logic          is_place;
  logic          is_take;
  logic          full;
  logic          place_ok;
  logic          take_ok;

  assign act     = pss_pkg::act_t'(action);
  assign len_ext = PW'(length);
  assign pos_ext = PW'(position);
  assign full    = (length == LW'(CAPACITY));

  // target index and kind of action
  always_comb begin
    tpos     = '0;
    is_place = 1'b0;
    is_take  = 1'b0;
    unique case (act)
      pss_pkg::ACT_PUSH_FRONT: begin
        is_place = 1'b1;
      end
      pss_pkg::ACT_PUSH_BACK: begin
        is_place = 1'b1;
        tpos     = len_ext;
      end
      pss_pkg::ACT_INSERT_AT: begin
        is_place = 1'b1;
        tpos     = pos_ext;
      end
      pss_pkg::ACT_POP_FRONT: begin
        is_take = 1'b1;
      end
      pss_pkg::ACT_POP_BACK: begin
        // empty list wraps to all ones, which fails the bound check below
        is_take = 1'b1;
        tpos    = len_ext - PW'(1);
      end
      pss_pkg::ACT_ERASE_AT: begin
        is_take = 1'b1;
        tpos    = pos_ext;
      end
      default: begin
      end
    endcase
  end

  // bound checks
  assign place_ok = is_place && !full && (tpos <= len_ext);
  assign take_ok  = is_take && (tpos < len_ext);

  assign ok         = place_ok || take_ok;
  assign ctrl.place = go && place_ok;
  assign ctrl.take  = go && take_ok;

endmodule

`default_nettype wire

// File: sv/pss_cell.sv
// one storage cell of the chain: holds element INDEX and shifts with its neighbors
// depends on pss_pkg
`default_nettype none

module pss_cell #(
  parameter int INDEX = 0,
  parameter int PW    = 7
) (
  input  wire logic                       clk,
  input  wire pss_pkg::cell_ctrl_t        ctrl,
  input  wire logic [PW-1:0]              tpos,
  input  wire logic [pss_pkg::DATA_W-1:0] left,
  input  wire logic [pss_pkg::DATA_W-1:0] right,
  input  wire logic [pss_pkg::DATA_W-1:0] value,
  output logic [pss_pkg::DATA_W-1:0]      data,
  output logic [pss_pkg::DATA_W-1:0]      tap
);

  logic [pss_pkg::DATA_W-1:0] data_next;
  logic                       at_target;
  logic                       above_target;

  assign at_target    = (tpos == PW'(INDEX));
  assign above_target = (PW'(INDEX) > tpos);

  // shift toward the front on take, toward the back on place
  always_comb begin
    data_next = data;
    if (ctrl.take && (at_target || above_target)) begin
      data_next = right;
    end else if (ctrl.place && above_target) begin
      data_next = left;
    end else if (ctrl.place && at_target) begin
      data_next = value;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // the word leaving the chain, zero elsewhere
  assign tap = (ctrl.take && at_target) ? data : '0;

endmodule

`default_nettype wire

// File: sv/positional_sequence_store_top.sv
// positional sequence store: the result strobe done rises on the
// cycle after start; one word accepted every cycle, busy stays low
// every action completes in a single update because all cells of the chain shift at once;
// the removed word goes through a registered or-tree of eight-cell groups
// reset clears the element count and the result strobe; cell contents are
// undefined until written
`default_nettype none

module positional_sequence_store_top #(
  parameter int CAPACITY = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [2:0]                        action,
  input  wire logic [pss_pkg::POS_W-1:0]         position,
  input  wire logic signed [pss_pkg::DATA_W-1:0] value,
  output logic                                   done,
  output logic signed [pss_pkg::DATA_W-1:0]      removed_value,
  output logic                                   ok,
  output logic [pss_pkg::CNT_W-1:0]              count
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int PW = (LW > pss_pkg::POS_W) ? LW : pss_pkg::POS_W;
  localparam int GS = 8;
  localparam int NG = (CAPACITY + GS - 1) / GS;

  logic                       accept;
  logic [LW-1:0]              length;
  logic [LW-1:0]              length_next;
  pss_pkg::cell_ctrl_t        ctrl;
  logic [PW-1:0]              tpos;
  logic                       act_ok;
  logic [pss_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic [pss_pkg::DATA_W-1:0] cell_tap  [CAPACITY];
  logic [pss_pkg::DATA_W-1:0] grp       [NG];
  logic [pss_pkg::DATA_W-1:0] grp_next  [NG];
  logic [pss_pkg::DATA_W-1:0] removed_or;

  // a new word is taken every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  pss_decode #(
    .CAPACITY (CAPACITY),
    .LW       (LW),
    .PW       (PW)
  ) u_decode (
    .go       (accept),
    .action   (action),
    .position (position),
    .length   (length),
    .ctrl     (ctrl),
    .tpos     (tpos),
    .ok       (act_ok)
  );

  // chain of cells, each fed by both neighbors
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [pss_pkg::DATA_W-1:0] left_in;
    logic [pss_pkg::DATA_W-1:0] right_in;

    if (k == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_inner_l
      assign left_in = cell_data[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_inner_r
      assign right_in = cell_data[k+1];
    end

    pss_cell #(
      .INDEX (k),
      .PW    (PW)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .tpos  (tpos),
      .left  (left_in),
      .right (right_in),
      .value (value),
      .data  (cell_data[k]),
      .tap   (cell_tap[k])
    );
  end

  // first level of the removal tree: or of each group of cells, registered
  for (genvar g = 0; g < NG; g++) begin : g_group
    always_comb begin
      grp_next[g] = '0;
      for (int i = 0; i < GS; i++) begin
        if (g * GS + i < CAPACITY) begin
          grp_next[g] = grp_next[g] | cell_tap[g * GS + i];
        end
      end
    end

    always_ff @(posedge clk) begin
      grp[g] <= grp_next[g];
    end
  end

  // second level of the removal tree
  always_comb begin
    removed_or = '0;
    for (int g = 0; g < NG; g++) begin
      removed_or = removed_or | grp[g];
    end
  end

  assign removed_value = $signed(removed_or);

  // element count
  always_comb begin
    length_next = length;
    if (ctrl.place) begin
      length_next = length + LW'(1);
    end else if (ctrl.take) begin
      length_next = length - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      done   <= 1'b0;
    end else begin
      length <= length_next;
      done   <= accept;
    end
  end

  // result status, reported with the strobe
  always_ff @(posedge clk) begin
    ok    <= act_ok;
    count <= pss_pkg::CNT_W'(length_next);
  end

endmodule

`default_nettype wire
